// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its trigger
`define PRST_ASSERT_NOW(label, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error("prst assertion failed");

// Property holds in the cycle after its trigger
`define PRST_ASSERT_NEXT(label, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error("prst assertion failed");

`endif

// ===== hw/rtl/prst_pkg.sv =====
// Types and constants of the retire stall accounting block
package prst_pkg;

	// RV32IM major opcodes
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] F7_MULDIV  = 7'h01;
	localparam logic [2:0] F3_DIV_MIN = 3'h4;

	// Configuration register file
	localparam int CFG_IDX_W = 3;
	localparam int PEN_W     = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_USE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_LATENCY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BRANCH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PIPE_DEPTH  = 3'd5;

	localparam logic [PEN_W-1:0] RST_LOAD_USE     = 8'd1;
	localparam logic [PEN_W-1:0] RST_DIV_LATENCY  = 8'd8;
	localparam logic [PEN_W-1:0] RST_DIV_INTERVAL = 8'd1;
	localparam logic [PEN_W-1:0] RST_BRANCH       = 8'd2;
	localparam logic [PEN_W-1:0] RST_JUMP         = 8'd2;
	localparam logic [PEN_W-1:0] RST_PIPE_DEPTH   = 8'd5;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam int STALL_W = 32;
	localparam int PRE_W   = PEN_W + 1;
	localparam int DELTA_W = PEN_W + 2;

	typedef struct packed {
		logic [PEN_W-1:0] lu_penalty;
		logic [PEN_W-1:0] div_latency;
		logic [PEN_W-1:0] divider_interval;
		logic [PEN_W-1:0] branch_penalty;
		logic [PEN_W-1:0] jump_penalty;
		logic [PEN_W-1:0] pipe_depth;
	} cfg_t;

	typedef struct packed {
		logic load_use;
		logic div_start;
		logic branch;
		logic jump;
	} flags_t;

	// One classified request as it sits in the queue
	typedef struct packed {
		logic               is_stall;
		logic [PRE_W-1:0]   pre_pen;
		logic [STALL_W-1:0] delta;
		logic [PEN_W-1:0]   lu_pen;
		logic [PEN_W-1:0]   div_pen;
		logic [PEN_W-1:0]   br_pen;
		logic [PEN_W-1:0]   jmp_pen;
		flags_t             flags;
	} item_t;

	// Value minus one, floored at zero
	function automatic logic [PEN_W-1:0] dec_floor(input logic [PEN_W-1:0] v);
		return (v != '0) ? v - 1'b1 : '0;
	endfunction

endpackage

// ===== hw/rtl/prst_front.sv =====
// Front end: decodes retired words, tracks hazards, classifies penalties
module prst_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  prst_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [31:0]                       instruction,
	input  logic                              was_taken,
	input  logic [prst_pkg::STALL_W-1:0]      stall_cycles,
	output logic                              push_valid,
	input  logic                              push_ready,
	output prst_pkg::item_t                   push_item
);

	logic       last_load_q;
	logic [4:0] last_dest_q;
	logic       last_div_q;

	logic [6:0] opc;
	logic [4:0] rd;
	logic [2:0] f3;
	logic [4:0] rs1;
	logic [4:0] rs2;
	logic [6:0] f7;
	logic       use1;
	logic       use2;
	logic       is_load;
	logic       is_br;
	logic       is_jump;
	logic       is_div;
	logic       lu_hit;
	logic [prst_pkg::PEN_W-1:0]   lat_pen;
	logic [prst_pkg::PEN_W-1:0]   div_pen;
	logic [prst_pkg::PEN_W-1:0]   lu_pen;
	logic [prst_pkg::PEN_W-1:0]   br_pen;
	logic [prst_pkg::PEN_W-1:0]   jmp_pen;
	logic [prst_pkg::PRE_W-1:0]   pre_pen;
	logic [prst_pkg::DELTA_W-1:0] ret_delta;
	logic       accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid & push_ready;

	// Instruction decode
	always_comb begin
		opc     = instruction[6:0];
		rd      = instruction[11:7];
		f3      = instruction[14:12];
		rs1     = instruction[19:15];
		rs2     = instruction[24:20];
		f7      = instruction[31:25];
		use1    = 1'b0;
		use2    = 1'b0;
		is_load = 1'b0;
		is_br   = 1'b0;
		is_jump = 1'b0;
		is_div  = 1'b0;
		unique case (opc)
			prst_pkg::OPC_JALR: begin
				use1    = 1'b1;
				is_jump = 1'b1;
			end
			prst_pkg::OPC_JAL: begin
				is_jump = 1'b1;
			end
			prst_pkg::OPC_BRANCH: begin
				use1  = 1'b1;
				use2  = 1'b1;
				is_br = 1'b1;
			end
			prst_pkg::OPC_LOAD: begin
				use1    = 1'b1;
				is_load = 1'b1;
			end
			prst_pkg::OPC_STORE: begin
				use1 = 1'b1;
			end
			prst_pkg::OPC_OP_IMM: begin
				use1 = 1'b1;
			end
			prst_pkg::OPC_OP: begin
				use1   = 1'b1;
				use2   = 1'b1;
				is_div = (f7 == prst_pkg::F7_MULDIV) && (f3 >= prst_pkg::F3_DIV_MIN);
			end
			default: begin
				use1 = 1'b0;
			end
		endcase
	end

	// Hazard detection and penalty selection
	always_comb begin
		lu_hit = last_load_q && (last_dest_q != 5'd0) &&
			((use1 && (rs1 == last_dest_q)) || (use2 && (rs2 == last_dest_q)));
		lu_pen  = lu_hit ? cfg.lu_penalty : '0;
		lat_pen = prst_pkg::dec_floor(cfg.div_latency);
		if (!is_div) begin
			div_pen = '0;
		end else if (last_div_q) begin
			div_pen = prst_pkg::dec_floor(cfg.divider_interval);
		end else begin
			div_pen = lat_pen;
		end
		br_pen    = (is_br && was_taken) ? cfg.branch_penalty : '0;
		jmp_pen   = is_jump ? cfg.jump_penalty : '0;
		pre_pen   = {1'b0, lu_pen} + {1'b0, div_pen};
		ret_delta = {1'b0, pre_pen} + {2'b00, br_pen} + {2'b00, jmp_pen};

		push_item.is_stall        = op;
		push_item.pre_pen         = pre_pen;
		push_item.delta           = op ? stall_cycles :
			{{(prst_pkg::STALL_W - prst_pkg::DELTA_W){1'b0}}, ret_delta};
		push_item.lu_pen          = lu_pen;
		push_item.div_pen         = div_pen;
		push_item.br_pen          = br_pen;
		push_item.jmp_pen         = jmp_pen;
		push_item.flags.load_use  = lu_hit;
		push_item.flags.div_start = is_div && !last_div_q && (lat_pen != '0);
		push_item.flags.branch    = is_br && was_taken;
		push_item.flags.jump      = is_jump;
	end

	// Previous-retire state; external stalls leave it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_load_q <= 1'b0;
			last_dest_q <= 5'd0;
			last_div_q  <= 1'b0;
		end else if (accept && !op) begin
			last_load_q <= is_load;
			last_dest_q <= is_load ? rd : 5'd0;
			last_div_q  <= is_div;
		end
	end

endmodule

// ===== hw/rtl/prst_queue.sv =====
// Small request queue between the front and back ends
module prst_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  prst_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output prst_pkg::item_t pop_item
);

	prst_pkg::item_t                  mem_q [prst_pkg::QUEUE_DEPTH];
	logic [prst_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [prst_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [prst_pkg::QUEUE_PTR_W:0]   count_q;
	logic                             push;
	logic                             pop;

	assign push_ready = (count_q != (prst_pkg::QUEUE_PTR_W + 1)'(prst_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hw/rtl/prst_back.sv =====
// Back end: saturating stall accumulators and result pipeline
module prst_back #(
	parameter int COUNT_WIDTH = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [prst_pkg::PEN_W-1:0]  pipe_depth,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  prst_pkg::item_t             pop_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [COUNT_WIDTH-1:0]      retire_stamp,
	output logic [COUNT_WIDTH-1:0]      cycles_so_far,
	output logic [COUNT_WIDTH-1:0]      retired_count,
	output prst_pkg::flags_t            flags,
	output logic [COUNT_WIDTH-1:0]      load_use_total,
	output logic [COUNT_WIDTH-1:0]      divider_total,
	output logic [COUNT_WIDTH-1:0]      branch_total,
	output logic [COUNT_WIDTH-1:0]      jump_total
);

	localparam int W = COUNT_WIDTH;

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[W] ? {W{1'b1}} : s[W-1:0];
	endfunction

	// Running counters
	logic [W-1:0] retire_q;
	logic [W-1:0] stall_q;
	logic [W-1:0] lu_q;
	logic [W-1:0] div_q;
	logic [W-1:0] br_q;
	logic [W-1:0] jmp_q;

	logic [W-1:0] retire_nx;
	logic [W-1:0] stall_mid_nx;
	logic [W-1:0] stall_nx;
	logic [W-1:0] lu_nx;
	logic [W-1:0] div_nx;
	logic [W-1:0] br_nx;
	logic [W-1:0] jmp_nx;

	logic adv;
	logic take;

	// Stage 1: counter snapshot
	logic             val_s1;
	logic [W-1:0]     retire_s1;
	logic [W-1:0]     stall_mid_s1;
	logic [W-1:0]     stall_s1;
	logic [W-1:0]     lu_s1;
	logic [W-1:0]     div_s1;
	logic [W-1:0]     br_s1;
	logic [W-1:0]     jmp_s1;
	prst_pkg::flags_t flags_s1;

	// Stage 2: retired count plus fill
	logic             val_s2;
	logic [W:0]       rf_s2;
	logic [W-1:0]     retire_s2;
	logic [W-1:0]     stall_mid_s2;
	logic [W-1:0]     stall_s2;
	logic [W-1:0]     lu_s2;
	logic [W-1:0]     div_s2;
	logic [W-1:0]     br_s2;
	logic [W-1:0]     jmp_s2;
	prst_pkg::flags_t flags_s2;

	// Stage 3: output register
	logic             val_s3;
	logic [W-1:0]     rcyc_s3;
	logic [W-1:0]     tcyc_s3;
	logic [W-1:0]     retire_s3;
	logic [W-1:0]     lu_s3;
	logic [W-1:0]     div_s3;
	logic [W-1:0]     br_s3;
	logic [W-1:0]     jmp_s3;
	prst_pkg::flags_t flags_s3;

	logic [prst_pkg::PEN_W-1:0] fill;
	logic [W+1:0] rcyc_sum;
	logic [W+1:0] tcyc_sum;

	// Whole pipe moves when the output register is free or being emptied
	assign adv       = !val_s3 || out_ready;
	assign pop_ready = adv;
	assign take      = pop_valid && adv;

	// Next counter values
	always_comb begin
		retire_nx    = sat_add(retire_q, W'(1));
		stall_mid_nx = sat_add(stall_q, W'(pop_item.pre_pen));
		stall_nx     = sat_add(stall_q, W'(pop_item.delta));
		lu_nx        = sat_add(lu_q, W'(pop_item.lu_pen));
		div_nx       = sat_add(div_q, W'(pop_item.div_pen));
		br_nx        = sat_add(br_q, W'(pop_item.br_pen));
		jmp_nx       = sat_add(jmp_q, W'(pop_item.jmp_pen));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retire_q <= '0;
			stall_q  <= '0;
			lu_q     <= '0;
			div_q    <= '0;
			br_q     <= '0;
			jmp_q    <= '0;
		end else if (take) begin
			stall_q <= stall_nx;
			if (!pop_item.is_stall) begin
				retire_q <= retire_nx;
				lu_q     <= lu_nx;
				div_q    <= div_nx;
				br_q     <= br_nx;
				jmp_q    <= jmp_nx;
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
		end else if (adv) begin
			val_s1 <= take && !pop_item.is_stall;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
		end
	end

	// Final sums; stage 3 saturates them as it registers them
	always_comb begin
		fill     = prst_pkg::dec_floor(pipe_depth);
		rcyc_sum = {1'b0, rf_s2} + {2'b00, stall_mid_s2};
		tcyc_sum = {1'b0, rf_s2} + {2'b00, stall_s2};
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			retire_s1    <= retire_nx;
			stall_mid_s1 <= stall_mid_nx;
			stall_s1     <= stall_nx;
			lu_s1        <= lu_nx;
			div_s1       <= div_nx;
			br_s1        <= br_nx;
			jmp_s1       <= jmp_nx;
			flags_s1     <= pop_item.flags;

			rf_s2        <= {1'b0, retire_s1} + (W + 1)'(fill);
			retire_s2    <= retire_s1;
			stall_mid_s2 <= stall_mid_s1;
			stall_s2     <= stall_s1;
			lu_s2        <= lu_s1;
			div_s2       <= div_s1;
			br_s2        <= br_s1;
			jmp_s2       <= jmp_s1;
			flags_s2     <= flags_s1;

			rcyc_s3   <= (rcyc_sum[W+1:W] != 2'b00) ? {W{1'b1}} : rcyc_sum[W-1:0];
			tcyc_s3   <= (tcyc_sum[W+1:W] != 2'b00) ? {W{1'b1}} : tcyc_sum[W-1:0];
			retire_s3 <= retire_s2;
			lu_s3     <= lu_s2;
			div_s3    <= div_s2;
			br_s3     <= br_s2;
			jmp_s3    <= jmp_s2;
			flags_s3  <= flags_s2;
		end
	end

	assign out_valid      = val_s3;
	assign retire_stamp   = rcyc_s3;
	assign cycles_so_far  = tcyc_s3;
	assign retired_count  = retire_s3;
	assign flags          = flags_s3;
	assign load_use_total = lu_s3;
	assign divider_total  = div_s3;
	assign branch_total   = br_s3;
	assign jump_total     = jmp_s3;

endmodule

// ===== hw/rtl/pipeline_retire_stall_accounting_core.sv =====
// An accepted retire request passes the queue and the back end's snapshot, fill
// and output stages before its result is valid. Throughput: one request per cycle
// while out_ready holds; a 4-entry queue decouples front and back. External stall
// requests give no result and cost one queue slot each. Reset clears the queue,
// pipeline, hazard state and counters and loads the configuration registers with
// their default values.
module pipeline_retire_stall_accounting_core #(
	parameter int COUNT_WIDTH = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [prst_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [prst_pkg::PEN_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [31:0]                       instruction,
	input  logic                              was_taken,
	input  logic [prst_pkg::STALL_W-1:0]      stall_cycles,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COUNT_WIDTH-1:0]            retire_stamp,
	output logic [COUNT_WIDTH-1:0]            cycles_so_far,
	output logic [COUNT_WIDTH-1:0]            retired_count,
	output logic                              load_use_flag,
	output logic                              divider_start_flag,
	output logic                              branch_redirect_flag,
	output logic                              jump_redirect_flag,
	output logic [COUNT_WIDTH-1:0]            load_use_total,
	output logic [COUNT_WIDTH-1:0]            divider_total,
	output logic [COUNT_WIDTH-1:0]            branch_total,
	output logic [COUNT_WIDTH-1:0]            jump_total
);

	prst_pkg::cfg_t   cfg_q;
	prst_pkg::item_t  push_item;
	prst_pkg::item_t  pop_item;
	prst_pkg::flags_t flags;
	logic             push_valid;
	logic             push_ready;
	logic             pop_valid;
	logic             pop_ready;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lu_penalty       <= prst_pkg::RST_LOAD_USE;
			cfg_q.div_latency      <= prst_pkg::RST_DIV_LATENCY;
			cfg_q.divider_interval <= prst_pkg::RST_DIV_INTERVAL;
			cfg_q.branch_penalty   <= prst_pkg::RST_BRANCH;
			cfg_q.jump_penalty     <= prst_pkg::RST_JUMP;
			cfg_q.pipe_depth       <= prst_pkg::RST_PIPE_DEPTH;
		end else if (cfg_write) begin
			unique case (cfg_index)
				prst_pkg::CFG_LOAD_USE:     cfg_q.lu_penalty       <= cfg_data;
				prst_pkg::CFG_DIV_LATENCY:  cfg_q.div_latency      <= cfg_data;
				prst_pkg::CFG_DIV_INTERVAL: cfg_q.divider_interval <= cfg_data;
				prst_pkg::CFG_BRANCH:       cfg_q.branch_penalty   <= cfg_data;
				prst_pkg::CFG_JUMP:         cfg_q.jump_penalty     <= cfg_data;
				prst_pkg::CFG_PIPE_DEPTH:   cfg_q.pipe_depth       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	prst_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.instruction  (instruction),
		.was_taken    (was_taken),
		.stall_cycles (stall_cycles),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	prst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	prst_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pipe_depth     (cfg_q.pipe_depth),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_item       (pop_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.retire_stamp   (retire_stamp),
		.cycles_so_far  (cycles_so_far),
		.retired_count  (retired_count),
		.flags          (flags),
		.load_use_total (load_use_total),
		.divider_total  (divider_total),
		.branch_total   (branch_total),
		.jump_total     (jump_total)
	);

	assign load_use_flag        = flags.load_use;
	assign divider_start_flag   = flags.div_start;
	assign branch_redirect_flag = flags.branch;
	assign jump_redirect_flag   = flags.jump;

endmodule

// ===== hw/rtl/prst_checker.sv =====
// Port-level checks for the retire stall accounting block, with its bind
`include "assert_macros.svh"

module prst_checker #(
	parameter int COUNT_WIDTH = 48
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [COUNT_WIDTH-1:0] retire_stamp,
	input logic [COUNT_WIDTH-1:0] cycles_so_far,
	input logic [COUNT_WIDTH-1:0] retired_count,
	input logic                   branch_redirect_flag,
	input logic                   jump_redirect_flag
);

	logic redirect;

	assign redirect = branch_redirect_flag | jump_redirect_flag;

	// A stalled result stays offered with the same count
	`PRST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(retired_count))

	// Redirect penalties only ever add to the retire cycle
	`PRST_ASSERT_NOW(a_total_ge_retire, out_valid, cycles_so_far >= retire_stamp)

	// Without a redirect the retire stamp and the running cycle total agree
	`PRST_ASSERT_NOW(a_no_redirect, out_valid && !redirect, cycles_so_far == retire_stamp)

	// Retire cycle never runs behind the retired count
	`PRST_ASSERT_NOW(a_cycle_ge_count, out_valid, retire_stamp >= retired_count)

	// A word is never both a branch and a jump
	`PRST_ASSERT_NOW(a_redirect_excl, out_valid, !(branch_redirect_flag && jump_redirect_flag))

endmodule

bind pipeline_retire_stall_accounting_core prst_checker #(
	.COUNT_WIDTH (COUNT_WIDTH)
) u_prst_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.out_valid            (out_valid),
	.out_ready            (out_ready),
	.retire_stamp         (retire_stamp),
	.cycles_so_far        (cycles_so_far),
	.retired_count        (retired_count),
	.branch_redirect_flag (branch_redirect_flag),
	.jump_redirect_flag   (jump_redirect_flag)
);
